FILE: rtl/core/escd_pkg.sv
`default_nettype none

package escd_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_FEW_HEX   = 3'd2,
    ST_NO_HEX    = 3'd3,
    ST_OCT_RANGE = 3'd4,
    ST_SURROGATE = 3'd5,
    ST_TOO_LARGE = 3'd6
  } status_t;

  // Configuration register indexes
  localparam logic REG_MASK_LOW  = 1'b0;
  localparam logic REG_MASK_HIGH = 1'b1;

  localparam int MASK_LOW_W  = 48;
  localparam int MASK_HIGH_W = 47;
  localparam int MAX_RESULTS = 4;

  // Results caused by one input word, handed from front to back
  typedef struct packed {
    logic [2:0]                   cnt;    // 1 to 4 valid bytes
    logic [MAX_RESULTS-1:0][7:0]  bytes;  // bytes[0] goes out first
    status_t                      status; // status of the final result
    logic                         done;   // final result closes the string
  } bundle_t;

endpackage

`default_nettype wire

FILE: rtl/core/escape_sequence_decoder_unit.sv
// Escape sequence decoder: unescapes a C style string, one raw byte per word.
// Input stream (s_axis_*): tdata carries the raw byte, tlast marks the last
// byte of a string. Output stream (m_axis_*): one decoded byte per word, tuser
// carries the status (0 ok, nonzero error with byte 0) and a string-done flag,
// tlast marks the last result caused by one input byte.
// Configuration (cfg_*): index 0 writes the low special mask (codes 32..79),
// index 1 the high special mask (codes 80..126); cfg_ready is always high.
// Write it only while the block is idle.
// Throughput: one input byte per cycle while the output side keeps up; an
// input byte yields 0 to 4 results and the output side sends one per cycle
// while the receiver takes them, so a byte with k results holds the output
// until all k have gone out. A QUEUE_DEPTH entry queue between decoder and
// output absorbs such bursts; the input stalls only when it fills.
// With the queue empty, the first result of an accepted byte is written into
// the queue and then loaded into the output register once that is free.
// When the receiver stalls, the output word holds and the queue fills, then
// s_axis_tready drops. Reset clears decode state, masks and the queue.
`default_nettype none

module escape_sequence_decoder_unit
  import escd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [7:0] in_byte
  input  wire logic                  s_axis_tlast,  // last_of_string
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
  output logic [3:0]                 m_axis_tuser,  // [2:0] status, [3] string_done
  output logic                       m_axis_tlast,  // run_end
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [MASK_LOW_W-1:0] cfg_data
);

  logic    q_full;
  logic    push;
  bundle_t push_bundle;
  logic    pop;
  logic    head_valid;
  bundle_t head;

  assign cfg_ready = 1'b1;

  escd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_byte     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  escd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop         (pop),
    .head_valid  (head_valid),
    .head        (head)
  );

  escd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/core/escd_front.sv
`default_nettype none

module escd_front
  import escd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_last,
  output logic                        in_ready,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_index,
  input  wire logic [MASK_LOW_W-1:0]  cfg_data,
  input  wire logic                   q_full,
  output logic                        push,
  output bundle_t                     push_bundle
);

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_ESC    = 3'd1,
    M_UNI    = 3'd2,
    M_OCT    = 3'd3,
    M_HEX    = 3'd4
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_U_LO   = 8'h75;
  localparam logic [7:0] CH_U_HI   = 8'h55;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_SPACE  = 8'd32;

  localparam logic [31:0] CP_ONE_MAX  = 32'h7F;
  localparam logic [31:0] CP_TWO_MAX  = 32'h7FF;
  localparam logic [31:0] CP_THREE_MAX = 32'hFFFF;
  localparam logic [31:0] CP_MAX      = 32'h10FFFF;
  localparam logic [31:0] SURR_LO     = 32'hD800;
  localparam logic [31:0] SURR_HI     = 32'hDFFF;

  // Hex digit decode: {ok, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  mode_t                  mode, mode_next;
  logic [31:0]            acc, acc_next;
  logic [3:0]             dl, dl_next;
  logic                   drop, drop_next;
  logic [MASK_LOW_W-1:0]  mask_lo;
  logic [MASK_HIGH_W-1:0] mask_hi;

  logic                   accept;
  logic [4:0]             hx;
  logic                   is_bad;
  logic                   is_special;
  logic                   is_oct;
  status_t                err;
  logic [2:0]             n;
  logic [MAX_RESULTS-1:0][7:0] bq;
  logic                   plain;
  logic [31:0]            cp;
  logic [8:0]             acc9;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the incoming byte
  assign hx     = hex_digit(in_byte);
  assign is_bad = (in_byte < CH_SPACE) || (in_byte == CH_DEL);
  assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);

  always_comb begin
    is_special = 1'b0;
    if (in_byte >= 8'd32 && in_byte <= 8'd79)
      is_special = mask_lo[6'(in_byte - 8'd32)];
    else if (in_byte >= 8'd80 && in_byte <= 8'd126)
      is_special = mask_hi[6'(in_byte - 8'd80)];
  end

  // Decode one word: next state and up to four results
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    dl_next   = dl;
    drop_next = drop;
    err       = ST_OK;
    n         = 3'd0;
    bq        = '0;
    plain     = 1'b0;
    cp        = 32'd0;
    acc9      = 9'd0;

    case (mode)
      M_ESC: begin
        mode_next = M_NORMAL;
        case (in_byte)
          CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK: begin
            bq[n[1:0]] = in_byte; n = n + 3'd1;
          end
          CH_A: begin bq[n[1:0]] = 8'd7;  n = n + 3'd1; end
          CH_B: begin bq[n[1:0]] = 8'd8;  n = n + 3'd1; end
          CH_F: begin bq[n[1:0]] = 8'd12; n = n + 3'd1; end
          CH_N: begin bq[n[1:0]] = 8'd10; n = n + 3'd1; end
          CH_R: begin bq[n[1:0]] = 8'd13; n = n + 3'd1; end
          CH_T: begin bq[n[1:0]] = 8'd9;  n = n + 3'd1; end
          CH_V: begin bq[n[1:0]] = 8'd11; n = n + 3'd1; end
          CH_U_LO, CH_U_HI: begin
            mode_next = M_UNI;
            acc_next  = 32'd0;
            dl_next   = (in_byte == CH_U_LO) ? 4'd4 : 4'd8;
          end
          CH_X: begin
            mode_next = M_HEX;
            acc_next  = 32'd0;
            dl_next   = 4'd2;
          end
          default: begin
            if (is_oct) begin
              mode_next = M_OCT;
              acc_next  = {29'd0, in_byte[2:0]};
              dl_next   = 4'd2;
            end else if (is_bad) begin
              err = ST_BAD_CHAR;
            end else begin
              if (!is_special) begin
                bq[n[1:0]] = CH_BSLASH; n = n + 3'd1;
              end
              bq[n[1:0]] = in_byte; n = n + 3'd1;
            end
          end
        endcase
      end
      M_UNI: begin
        if (!hx[4]) begin
          err = ST_FEW_HEX;
        end else begin
          acc_next = {acc[27:0], hx[3:0]};
          dl_next  = 4'(dl - 4'd1);
          if (dl_next == 4'd0) begin
            mode_next = M_NORMAL;
            cp = acc_next;
            // Encode the code point as UTF-8
            if (cp >= SURR_LO && cp <= SURR_HI) begin
              err = ST_SURROGATE;
            end else if (cp <= CP_ONE_MAX) begin
              bq[0] = cp[7:0]; n = 3'd1;
            end else if (cp <= CP_TWO_MAX) begin
              bq[0] = {3'b110, cp[10:6]};
              bq[1] = {2'b10, cp[5:0]};
              n = 3'd2;
            end else if (cp <= CP_THREE_MAX) begin
              bq[0] = {4'b1110, cp[15:12]};
              bq[1] = {2'b10, cp[11:6]};
              bq[2] = {2'b10, cp[5:0]};
              n = 3'd3;
            end else if (cp <= CP_MAX) begin
              bq[0] = {5'b11110, cp[20:18]};
              bq[1] = {2'b10, cp[17:12]};
              bq[2] = {2'b10, cp[11:6]};
              bq[3] = {2'b10, cp[5:0]};
              n = 3'd4;
            end else begin
              err = ST_TOO_LARGE;
            end
          end
        end
      end
      M_HEX: begin
        if (!hx[4]) begin
          if (dl == 4'd2) begin
            err = ST_NO_HEX;
          end else begin
            mode_next = M_NORMAL;
            bq[n[1:0]] = acc[7:0]; n = n + 3'd1;
            plain = 1'b1;
          end
        end else begin
          acc_next = {24'd0, acc[3:0], hx[3:0]};
          dl_next  = 4'(dl - 4'd1);
          if (dl_next == 4'd0) begin
            mode_next = M_NORMAL;
            bq[n[1:0]] = acc_next[7:0]; n = n + 3'd1;
          end
        end
      end
      M_OCT: begin
        if (!is_oct) begin
          mode_next = M_NORMAL;
          bq[n[1:0]] = acc[7:0]; n = n + 3'd1;
          plain = 1'b1;
        end else begin
          acc9     = {acc[5:0], in_byte[2:0]};
          acc_next = {23'd0, acc9};
          dl_next  = 4'(dl - 4'd1);
          if (dl_next == 4'd0) begin
            mode_next = M_NORMAL;
            if (acc9[8]) err = ST_OCT_RANGE;
            else begin
              bq[n[1:0]] = acc9[7:0]; n = n + 3'd1;
            end
          end
        end
      end
      default: begin
        mode_next = M_NORMAL;
        plain     = 1'b1;
      end
    endcase

    // Ordinary byte, also the one that ends an octal or \x escape
    if (plain) begin
      if (in_byte == CH_BSLASH) mode_next = M_ESC;
      else if (is_bad) err = ST_BAD_CHAR;
      else begin
        bq[n[1:0]] = in_byte; n = n + 3'd1;
      end
    end

    // Flush a pending escape at end of string
    if (err == ST_OK && in_last) begin
      case (mode_next)
        M_ESC: begin bq[n[1:0]] = CH_BSLASH; n = n + 3'd1; end
        M_UNI: err = ST_FEW_HEX;
        M_HEX: begin
          if (dl_next == 4'd2) err = ST_NO_HEX;
          else begin
            bq[n[1:0]] = acc_next[7:0]; n = n + 3'd1;
          end
        end
        M_OCT: begin bq[n[1:0]] = acc_next[7:0]; n = n + 3'd1; end
        default: ;
      endcase
    end

    // Close with an error result, or clear state at end of string
    if (err != ST_OK) begin
      bq[n[1:0]] = 8'd0; n = n + 3'd1;
      mode_next = M_NORMAL;
      acc_next  = 32'd0;
      dl_next   = 4'd0;
      drop_next = !in_last;
    end else if (in_last) begin
      mode_next = M_NORMAL;
      acc_next  = 32'd0;
      dl_next   = 4'd0;
    end

    // Drop everything up to the end of the string after an error
    if (drop) begin
      mode_next = mode;
      acc_next  = acc;
      dl_next   = dl;
      drop_next = !in_last;
      n         = 3'd0;
      err       = ST_OK;
    end
  end

  assign push               = accept && (n != 3'd0);
  assign push_bundle.cnt    = n;
  assign push_bundle.bytes  = bq;
  assign push_bundle.status = err;
  assign push_bundle.done   = in_last || (err != ST_OK);

  // Hold decode state, advance on each accepted word; load the masks on config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_NORMAL;
      acc     <= 32'd0;
      dl      <= 4'd0;
      drop    <= 1'b0;
      mask_lo <= '0;
      mask_hi <= '0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        acc  <= acc_next;
        dl   <= dl_next;
        drop <= drop_next;
      end
      if (cfg_valid) begin
        if (cfg_index == REG_MASK_LOW) mask_lo <= cfg_data;
        else if (cfg_index == REG_MASK_HIGH) mask_hi <= cfg_data[MASK_HIGH_W-1:0];
      end
    end
  end

  a_drop_normal: assert property (@(posedge clk) disable iff (rst)
    drop |-> (mode == M_NORMAL) && (dl == 4'd0))
    else $error("dropping while an escape is pending");

  a_err_ends_string: assert property (@(posedge clk) disable iff (rst)
    (push && push_bundle.status != ST_OK && !in_last) |=> drop)
    else $error("error did not start dropping");

endmodule

`default_nettype wire

FILE: rtl/core/escd_queue.sv
`default_nettype none

module escd_queue
  import escd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_bundle,
  output logic         full,
  input  wire logic    pop,
  output logic         head_valid,
  output bundle_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bundle_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Store words at the tail
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_bundle;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      if (push && !pop)      count <= CNT_W'(count + 1'b1);
      else if (!push && pop) count <= CNT_W'(count - 1'b1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue overflow");

endmodule

`default_nettype wire

FILE: rtl/core/escd_back.sv
`default_nettype none

module escd_back
  import escd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    head_valid,
  input  wire bundle_t head,
  output logic         pop,
  output logic         m_axis_tvalid,
  input  wire logic    m_axis_tready,
  output logic [7:0]   m_axis_tdata,
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic [1:0] idx;
  logic       last_item;
  logic       load;

  assign last_item = (idx == 2'(head.cnt - 3'd1));
  assign load      = head_valid && (!m_axis_tvalid || m_axis_tready);
  assign pop       = load && last_item;

  // Step through the head word's results, one per cycle while the receiver takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= 2'd0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        idx           <= last_item ? 2'd0 : 2'(idx + 2'd1);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= head.bytes[idx];
      m_axis_tuser <= {last_item && head.done, last_item ? head.status : ST_OK};
      m_axis_tlast <= last_item;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ({1'b0, idx} < head.cnt))
    else $error("result index beyond word");

  a_err_closes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2:0] != ST_OK) |-> (m_axis_tlast && m_axis_tuser[3]
      && m_axis_tdata == 8'd0))
    else $error("error result not final");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import escd_pkg::*;

  // Decoder modes tracked by the predictor
  typedef enum logic [2:0] {MD_NORMAL, MD_ESC, MD_UNI, MD_OCT, MD_HEX} mode_e;

  // One expected output word
  typedef struct packed {
    logic [7:0] data;
    status_t    code;
    logic       run_end;
    logic       done;
  } word_t;

  localparam int QUIET_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'd0;  // [7:0] in_byte
  logic                  s_axis_tlast = 1'b0;  // last_of_string
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;         // [7:0] out_byte
  logic [3:0]            m_axis_tuser;         // [2:0] status, [3] string_done
  logic                  m_axis_tlast;         // run_end
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = REG_MASK_LOW;
  logic [MASK_LOW_W-1:0] cfg_data = '0;

  // Predictor state
  logic [MASK_LOW_W-1:0]  spec_lo = '0;
  logic [MASK_HIGH_W-1:0] spec_hi = '0;
  mode_e                  mode = MD_NORMAL;
  logic [31:0]            acc = '0;
  logic [3:0]             left = '0;
  logic                   dropping = 1'b0;
  logic [7:0]             burst[$];
  word_t                  expected_words[$];
  int                     decoded_cnt = 0;
  int                     mismatches = 0;
  bit                     idle_en = 1'b1;
  logic [7:0]             text[$];
  int                     stall_left = 0;
  int                     quiet = 0;

  escape_sequence_decoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Append one decoded byte to the current burst
  function automatic void emit(logic [7:0] b);
    burst = {burst, b};
  endfunction

  // Append one raw byte to the pending text
  function automatic void add_char(logic [7:0] c);
    text = {text, c};
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Only printable codes can be special
  function automatic bit is_special(logic [7:0] c);
    if (c >= 8'd32 && c <= 8'd79) return spec_lo[c - 8'd32];
    if (c >= 8'd80 && c <= 8'd126) return spec_hi[c - 8'd80];
    return 1'b0;
  endfunction

  // Encode a code point as UTF-8, rejecting surrogates and values past the range
  function automatic status_t put_utf8(logic [31:0] cp);
    if (cp >= 32'hD800 && cp <= 32'hDFFF) return ST_SURROGATE;
    if (cp <= 32'h7F) begin
      emit(cp[7:0]);
    end else if (cp <= 32'h7FF) begin
      emit({3'b110, cp[10:6]});
      emit({2'b10, cp[5:0]});
    end else if (cp <= 32'hFFFF) begin
      emit({4'b1110, cp[15:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end else if (cp <= 32'h10FFFF) begin
      emit({5'b11110, cp[20:18]});
      emit({2'b10, cp[17:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end else begin
      return ST_TOO_LARGE;
    end
    return ST_OK;
  endfunction

  function automatic status_t plain_char(logic [7:0] c);
    if (c == "\\") begin
      mode = MD_ESC;
      return ST_OK;
    end
    if (c < 8'd32 || c == 8'd127) return ST_BAD_CHAR;
    emit(c);
    return ST_OK;
  endfunction

  function automatic status_t escape_char(logic [7:0] c);
    mode = MD_NORMAL;
    case (c)
      "\\", "'", "\"", "?": emit(c);
      "a": emit(8'd7);
      "b": emit(8'd8);
      "f": emit(8'd12);
      "n": emit(8'd10);
      "r": emit(8'd13);
      "t": emit(8'd9);
      "v": emit(8'd11);
      "u", "U": begin
        mode = MD_UNI;
        acc  = '0;
        left = (c == "u") ? 4'd4 : 4'd8;
      end
      "x": begin
        mode = MD_HEX;
        acc  = '0;
        left = 4'd2;
      end
      default: begin
        if (c >= "0" && c <= "7") begin
          mode = MD_OCT;
          acc  = {29'd0, c[2:0]};
          left = 4'd2;
        end else if (c < 8'd32 || c == 8'd127) begin
          return ST_BAD_CHAR;
        end else begin
          // unknown escape keeps its backslash unless the char is special
          if (!is_special(c)) emit("\\");
          emit(c);
        end
      end
    endcase
    return ST_OK;
  endfunction

  function automatic status_t process_char(logic [7:0] c);
    int h;
    h = hex_digit(c);
    case (mode)
      MD_ESC: return escape_char(c);
      MD_UNI: begin
        if (h < 0) return ST_FEW_HEX;
        acc  = {acc[27:0], h[3:0]};
        left = left - 4'd1;
        if (left == 4'd0) begin
          mode = MD_NORMAL;
          return put_utf8(acc);
        end
        return ST_OK;
      end
      MD_HEX: begin
        // a non-hex byte ends the escape and is decoded in the same step
        if (h < 0) begin
          if (left == 4'd2) return ST_NO_HEX;
          mode = MD_NORMAL;
          emit(acc[7:0]);
          return plain_char(c);
        end
        acc  = {24'd0, acc[3:0], h[3:0]};
        left = left - 4'd1;
        if (left == 4'd0) begin
          mode = MD_NORMAL;
          emit(acc[7:0]);
        end
        return ST_OK;
      end
      MD_OCT: begin
        if (c < "0" || c > "7") begin
          mode = MD_NORMAL;
          emit(acc[7:0]);
          return plain_char(c);
        end
        acc  = {23'd0, acc[5:0], c[2:0]};
        left = left - 4'd1;
        if (left == 4'd0) begin
          mode = MD_NORMAL;
          if (acc > 32'd255) return ST_OCT_RANGE;
          emit(acc[7:0]);
        end
        return ST_OK;
      end
      default: return plain_char(c);
    endcase
  endfunction

  // Flush whatever escape is still open at the end of a string
  function automatic status_t finish_text();
    mode_e m;
    m = mode;
    mode = MD_NORMAL;
    case (m)
      MD_ESC: emit("\\");
      MD_UNI: return ST_FEW_HEX;
      MD_HEX: begin
        if (left == 4'd2) return ST_NO_HEX;
        emit(acc[7:0]);
      end
      MD_OCT: emit(acc[7:0]);
      default: ;
    endcase
    return ST_OK;
  endfunction

  // Work out the words one accepted input byte yields
  function automatic void decode_byte(logic [7:0] c, logic lst);
    status_t err;
    word_t   w;
    if (dropping) begin
      if (lst) dropping = 1'b0;
      return;
    end
    decoded_cnt++;
    burst.delete();
    err = process_char(c);
    if (err == ST_OK && lst) err = finish_text();
    foreach (burst[i]) begin
      w.data    = burst[i];
      w.code    = ST_OK;
      w.run_end = (err == ST_OK) && (i == burst.size() - 1);
      w.done    = w.run_end && lst;
      expected_words = {expected_words, w};
    end
    if (err != ST_OK) begin
      w.data    = 8'd0;
      w.code    = err;
      w.run_end = 1'b1;
      w.done    = 1'b1;
      expected_words = {expected_words, w};
      dropping  = !lst;
    end
    if (err != ST_OK || lst) begin
      mode = MD_NORMAL;
      acc  = '0;
      left = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: track config, predict on input words, check output words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_t w;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MASK_LOW) spec_lo = cfg_data;
        else spec_hi = cfg_data[MASK_HIGH_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte %02h tuser %h run_end %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          w = expected_words.pop_front();
          if (m_axis_tdata !== w.data) begin
            $error("out_byte: expected %02h, actual %02h", w.data, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser[2:0] !== w.code) begin
            $error("status: expected %0d, actual %0d", w.code, m_axis_tuser[2:0]);
            mismatches++;
          end
          if (m_axis_tlast !== w.run_end) begin
            $error("run_end: expected %b, actual %b", w.run_end, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser[3] !== w.done) begin
            $error("string_done: expected %b, actual %b", w.done, m_axis_tuser[3]);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: while idle_en is set, start stalls at random, each of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_byte(logic [7:0] c, logic lst);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Send the queued text as one string
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_text();
  endtask

  // Write both masks back to back, holding valid across the pair
  task automatic write_masks(logic [MASK_LOW_W-1:0] lo, logic [MASK_LOW_W-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MASK_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_MASK_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every expected word is out, plus a margin for dropped input
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic void push_hex(logic [31:0] v, int ndig);
    for (int i = ndig - 1; i >= 0; i--) add_char(hex_char(v[i*4 +: 4]));
  endfunction

  // Append one random token, mostly well-formed escapes with random content
  function automatic void add_token();
    int          kind;
    int          r;
    logic [31:0] cp;
    logic [7:0]  simple_set[11] = '{"\\", "'", "\"", "?", "a", "b", "f", "n", "r", "t", "v"};
    kind = $urandom_range(0, 99);
    r    = $urandom_range(0, 9);
    if (kind < 30) begin
      add_char(8'($urandom_range(32, 126)));
    end else if (kind < 44) begin
      add_char("\\");
      add_char(simple_set[$urandom_range(0, 10)]);
    end else if (kind < 54) begin
      add_char("\\");
      repeat ($urandom_range(1, 3)) add_char(8'("0" + $urandom_range(0, 7)));
    end else if (kind < 62) begin
      add_char("\\");
      add_char("x");
      push_hex($urandom, $urandom_range(1, 2));
    end else if (kind < 72) begin
      cp = (r < 2) ? $urandom_range(32'hD800, 32'hDFFF) : $urandom_range(0, 32'hFFFF);
      add_char("\\");
      add_char("u");
      push_hex(cp, 4);
    end else if (kind < 80) begin
      if (r < 2) cp = $urandom;
      else if (r < 3) cp = $urandom_range(32'hD800, 32'hDFFF);
      else if (r < 5) cp = $urandom_range(0, 32'h7FF);
      else cp = $urandom_range(0, 32'h10FFFF);
      add_char("\\");
      add_char("U");
      push_hex(cp, 8);
    end else if (kind < 86) begin
      add_char("\\");
      add_char(8'($urandom_range(32, 126)));
    end else if (kind < 91) begin
      add_char(8'($urandom_range(128, 255)));
    end else if (kind < 96) begin
      // truncated or malformed escape
      add_char("\\");
      case (r % 5)
        0: ;
        1: add_char("x");
        2: begin
          add_char("u");
          push_hex($urandom, $urandom_range(0, 3));
        end
        3: begin
          add_char("U");
          push_hex($urandom, $urandom_range(0, 7));
        end
        default: add_char(($urandom_range(0, 3) == 0) ? 8'd127 : 8'($urandom_range(0, 31)));
      endcase
    end else begin
      add_char(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Escapes ended by a non-digit, and escapes still open at the end of a string
  task automatic test_pending_escapes();
    send_str("\\7\\x4g\\");
    send_str("\\x");
    send_str("\\u1");
    drain();
  endtask

  task automatic test_code_points();
    send_str("\\uDFFF");
    send_str("\\uFFFF");
    drain();
  endtask

  // Octal overflow mid-string drops the rest; control and high bytes
  task automatic test_errors_and_drop();
    send_str("\\400z");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain();
  endtask

  // Edges of both masks, all set then all clear
  task automatic test_special_set();
    write_masks('1, '1);
    send_str("\\ \\O\\P\\~");
    drain();
    write_masks('0, '0);
    send_str("\\ \\O\\P\\~");
    drain();
  endtask

  task automatic test_random_text(int n_items, logic [MASK_LOW_W-1:0] lo,
                                  logic [MASK_LOW_W-1:0] hi);
    int stop_at;
    write_masks(lo, hi);
    stop_at = decoded_cnt + n_items;
    while (decoded_cnt < stop_at) begin
      repeat ($urandom_range(1, 6)) add_token();
      send_text();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pending_escapes();
    test_code_points();
    test_errors_and_drop();
    test_special_set();
    test_random_text(150, MASK_LOW_W'({$urandom, $urandom}),
                     MASK_LOW_W'({$urandom, $urandom}));
    test_random_text(150, MASK_LOW_W'({$urandom, $urandom} & {$urandom, $urandom}),
                     MASK_LOW_W'({$urandom, $urandom} & {$urandom, $urandom}));
    test_random_text(100, '1, '1);
    // full rate on both sides for the final stretch
    idle_en = 1'b0;
    test_random_text(100, MASK_LOW_W'({$urandom, $urandom}),
                     MASK_LOW_W'({$urandom, $urandom}));
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: escape_sequence_decoder_unit.f
rtl/core/escd_pkg.sv
rtl/core/escd_front.sv
rtl/core/escd_queue.sv
rtl/core/escd_back.sv
rtl/core/escape_sequence_decoder_unit.sv
sim/testbench.sv
